// File: hw/rtl/gmsu_pkg.sv
// shared types and constants for the gap material state update unit
// no dependencies; used by the interfaces, the datapath, the top level and the checker
package gmsu_pkg;

  localparam int KindW   = 2;
  localparam int StrainW = 32;
  localparam int StressW = 31;
  localparam int ModW    = 31;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  typedef enum logic [KindW-1:0] {
    KIND_UPDATE = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_RESET  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_LOAD   = 2'd1,
    DIR_UNLOAD = 2'd2
  } dir_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_YIELD   = 2'd1,
    CFG_GAP     = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_t;

  localparam logic [ModW-1:0]    ModulusReset = 31'd65536;
  localparam logic [StressW-1:0] YieldReset   = 31'd65536;
  localparam logic [StrainW-1:0] GapReset     = 32'd0;

  typedef struct packed {
    logic signed [StrainW-1:0] strain;
    logic [StressW-1:0]        stress;
    logic                      stiff_zero;
    logic signed [StrainW-1:0] rev_strain;
    dir_t                      dir;
  } mat_state_t;

  typedef struct packed {
    logic [ModW-1:0]           modulus;
    logic [StressW-1:0]        yield_lim;
    logic signed [StrainW-1:0] gap;
  } mat_cfg_t;

  localparam mat_state_t StateZero = '{
    strain:     '0,
    stress:     '0,
    stiff_zero: 1'b0,
    rev_strain: '0,
    dir:        DIR_NONE
  };

endpackage

// File: hw/rtl/gmsu_item_if.sv
// request channel: operation kind and trial strain
// depends on gmsu_pkg
interface gmsu_item_if import gmsu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  kind_t                     kind;
  logic signed [StrainW-1:0] strain;

  modport source (output valid, kind, strain, input ready);
  modport sink   (input valid, kind, strain, output ready);
endinterface

// File: hw/rtl/gmsu_result_if.sv
// result channel: trial stress and tangent stiffness
// depends on gmsu_pkg
interface gmsu_result_if import gmsu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StressW-1:0] stress;
  logic [ModW-1:0]    stiffness;

  modport source (output valid, stress, stiffness, input ready);
  modport sink   (input valid, stress, stiffness, output ready);
endinterface

// File: hw/rtl/gmsu_cfg_if.sv
// configuration write channel: register index and write data
// depends on gmsu_pkg
interface gmsu_cfg_if import gmsu_pkg::*; ();
  logic               valid;
  logic               ready;
  cfg_idx_t           index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/gmsu_update_datapath.sv
// trial state update for one strain request: increment, gap shift, scaled product, clamp
// depends on gmsu_pkg; purely combinational
module gmsu_update_datapath import gmsu_pkg::*; (
  input  mat_state_t                committed,
  input  mat_state_t                pending,
  input  mat_cfg_t                  cfg,
  input  logic signed [StrainW-1:0] strain,
  output mat_state_t                upd
);

  logic signed [StrainW:0]   inc;
  logic                      inc_zero;
  dir_t                      tdir;
  logic signed [StrainW-1:0] rev;
  logic signed [StrainW+1:0] gap_d;
  logic                      use_gap;
  logic signed [StrainW+2:0] inc_sel;
  logic signed [ModW:0]      mod_s;
  logic signed [66:0]        prod;
  logic signed [36:0]        term;
  logic signed [37:0]        sum;
  logic                      neg;
  logic                      over;

  assign inc      = $signed({strain[StrainW-1], strain})
                  - $signed({committed.strain[StrainW-1], committed.strain});
  assign inc_zero = (inc == '0);
  assign tdir     = inc[StrainW] ? DIR_UNLOAD : DIR_LOAD;

  always_comb begin
    rev     = committed.rev_strain;
    use_gap = 1'b0;
    if (tdir == DIR_LOAD && committed.dir == DIR_LOAD && committed.stress == '0) begin
      use_gap = 1'b1;
    end else if (tdir == DIR_LOAD && committed.dir == DIR_UNLOAD) begin
      rev     = committed.strain;
      use_gap = (committed.stress == '0);
    end
  end

  // strain minus gap minus reverse strain, floored at zero
  assign gap_d = $signed({{2{strain[StrainW-1]}}, strain})
               - $signed({{2{cfg.gap[StrainW-1]}}, cfg.gap})
               - $signed({{2{rev[StrainW-1]}}, rev});

  always_comb begin
    if (use_gap) begin
      inc_sel = gap_d[StrainW+1] ? '0 : $signed({1'b0, gap_d});
    end else begin
      inc_sel = $signed({{2{inc[StrainW]}}, inc});
    end
  end

  assign mod_s = $signed({1'b0, cfg.modulus});
  assign prod  = inc_sel * mod_s;
  assign term  = prod[66:30];
  assign sum   = $signed({term[36], term}) + $signed({7'b0, committed.stress});
  assign neg   = sum[37];
  assign over  = !neg && (sum[36:0] > {6'b0, cfg.yield_lim});

  always_comb begin
    upd        = pending;
    upd.strain = strain;
    if (!inc_zero) begin
      upd.rev_strain = rev;
      upd.dir        = tdir;
      upd.stiff_zero = neg || over;
      if (neg) begin
        upd.stress = '0;
      end else if (over) begin
        upd.stress = cfg.yield_lim;
      end else begin
        upd.stress = sum[StressW-1:0];
      end
    end
  end

endmodule

// File: hw/rtl/gap_material_state_update_unit.sv
// path: a request passes the input register and then the result register before its result shows
// throughput: one request per cycle while results are taken; the state update closes in the cycle a request
//   moves from the input register to the result register
// reset: synchronous, clears committed and trial state to zero and loads register defaults
// depends on gmsu_pkg, the channel interfaces and gmsu_update_datapath
module gap_material_state_update_unit import gmsu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  gmsu_cfg_if.sink      cfg,
  gmsu_item_if.sink     item,
  gmsu_result_if.source result
);

  mat_cfg_t                  cfg_regs;
  mat_state_t                committed;
  mat_state_t                committed_next;
  mat_state_t                pending;
  mat_state_t                pending_next;
  mat_state_t                upd;
  logic                      s1_valid;
  kind_t                     s1_kind;
  logic signed [StrainW-1:0] s1_strain;
  logic                      advance;
  logic                      out_valid;
  logic [StressW-1:0]        out_stress;
  logic [ModW-1:0]           out_stiffness;

  assign cfg.ready  = 1'b1;
  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.modulus   <= ModulusReset;
      cfg_regs.yield_lim <= YieldReset;
      cfg_regs.gap       <= GapReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MODULUS: cfg_regs.modulus   <= cfg.data[ModW-1:0];
        CFG_YIELD:   cfg_regs.yield_lim <= cfg.data[StressW-1:0];
        CFG_GAP:     cfg_regs.gap       <= $signed(cfg.data);
        CFG_NONE:    ;
      endcase
    end
  end

  gmsu_update_datapath u_dp (
    .committed (committed),
    .pending   (pending),
    .cfg       (cfg_regs),
    .strain    (s1_strain),
    .upd       (upd)
  );

  always_comb begin
    committed_next = committed;
    pending_next   = pending;
    if (advance) begin
      unique case (s1_kind)
        KIND_UPDATE: pending_next = upd;
        KIND_COMMIT: committed_next = pending;
        KIND_RESET: begin
          pending_next.strain     = committed.strain;
          pending_next.stress     = committed.stress;
          pending_next.stiff_zero = committed.stiff_zero;
        end
        KIND_CLEAR: begin
          committed_next          = StateZero;
          pending_next.strain     = StateZero.strain;
          pending_next.stress     = StateZero.stress;
          pending_next.stiff_zero = StateZero.stiff_zero;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed <= StateZero;
      pending   <= StateZero;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      committed <= committed_next;
      pending   <= pending_next;
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind   <= item.kind;
      s1_strain <= item.strain;
    end
    if (advance) begin
      out_stress    <= pending_next.stress;
      out_stiffness <= pending_next.stiff_zero ? '0 : cfg_regs.modulus;
    end
  end

  assign result.valid     = out_valid;
  assign result.stress    = out_stress;
  assign result.stiffness = out_stiffness;

endmodule

// File: hw/rtl/gmsu_checker.sv
// port-level checks for the gap material state update unit, attached by bind
// depends on gmsu_pkg and gap_material_state_update_unit
module gmsu_checker import gmsu_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [StressW-1:0] out_stress,
  input logic [ModW-1:0]    out_stiffness
);

  logic [1:0] outstanding;
  logic [1:0] outstanding_next;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    outstanding_next = outstanding;
    if (in_acc && !out_acc) begin
      outstanding_next = outstanding + 2'd1;
    end else if (!in_acc && out_acc) begin
      outstanding_next = outstanding - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding_next;
    end
  end

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // no invented results
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 2'd0)
    else $error("result without a pending request");

  // two holding stages at most
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more requests in flight than stages");

  // a request passes the input register before its result shows
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (outstanding == 2'd0 && in_acc) |=> !out_valid)
    else $error("result earlier than the input register allows");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_stress) && $stable(out_stiffness))
    else $error("stalled result changed");

endmodule

bind gap_material_state_update_unit gmsu_checker u_gmsu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item.valid),
  .in_ready      (item.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_stress    (result.stress),
  .out_stiffness (result.stiffness)
);
